// ===== rtl/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants for the rolling regression slope core.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

    localparam int MAX_WINDOW  = 256;
    localparam int RING_AW     = $clog2(MAX_WINDOW);
    localparam int SAMPLE_BITS = 24;
    localparam int SUM1_BITS   = 32;
    localparam int SUM2_BITS   = 56;
    localparam int WLEN_BITS   = 9;
    localparam int BETA_BITS   = 14;
    localparam int FLOOR_BITS  = 32;
    localparam int FRAC_BITS   = 12;
    localparam int WIDE_BITS   = 64;
    localparam int MPLIER_BITS = 32;
    localparam int CNT_BITS    = 6;
    localparam int DIV_STEPS   = WIDE_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

    localparam logic [BETA_BITS-1:0] BETA_ONE     = 14'd4096;
    localparam logic [BETA_BITS-1:0] BETA_MAXCODE = 14'h3FFF;

    localparam logic [WLEN_BITS-1:0]  WLEN_RESET  = 9'd128;
    localparam logic [WLEN_BITS-1:0]  WLEN_MIN    = 9'd2;
    localparam logic [WLEN_BITS-1:0]  WLEN_MAX    = 9'd256;
    localparam logic [BETA_BITS-1:0]  BMIN_RESET  = 14'd1229;
    localparam logic [BETA_BITS-1:0]  BMAX_RESET  = 14'd12288;
    localparam logic [FLOOR_BITS-1:0] FLOOR_RESET = 32'd110000;

    // register indexes on the write port
    typedef enum logic [1:0] {
        REG_WINDOW_LEN  = 2'd0,
        REG_BETA_MIN    = 2'd1,
        REG_BETA_MAX    = 2'd2,
        REG_DENOM_FLOOR = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ISSUE,
        ST_WAIT,
        ST_DIV,
        ST_DONE
    } state_t;

    // products taken one after another by the serial multiplier
    typedef enum logic [3:0] {
        OP_XY,
        OP_OXY,
        OP_XX,
        OP_OXX,
        OP_NSXX,
        OP_SXSX,
        OP_FLOOR,
        OP_NSXY,
        OP_SXSY
    } op_t;

    typedef struct packed {
        logic                   start;
        logic [WIDE_BITS-1:0]   mcand;
        logic [MPLIER_BITS-1:0] mplier;
        logic [CNT_BITS-1:0]    nbits;
    } mul_req_t;

    typedef struct packed {
        logic                 start;
        logic [WIDE_BITS-1:0] num;
        logic [WIDE_BITS-1:0] den;
    } div_req_t;

endpackage

`default_nettype wire

// ===== rtl/rrs_ring.sv =====
// ----------------------------------------------------------------------------
// rrs_ring
// Sample pair ring: one read-before-write port, per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_ring (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                clear,
    input  wire logic                                we,
    input  wire logic [rrs_pkg::RING_AW-1:0]         addr,
    input  wire logic [2*rrs_pkg::SAMPLE_BITS-1:0]   wdata,
    output logic      [2*rrs_pkg::SAMPLE_BITS-1:0]   rdata
);

    logic [2*rrs_pkg::SAMPLE_BITS-1:0] mem [rrs_pkg::MAX_WINDOW];
    logic [rrs_pkg::MAX_WINDOW-1:0]    valid_reg;
    logic [2*rrs_pkg::SAMPLE_BITS-1:0] rdata_reg;
    logic                              rvalid_reg;

    // storage and registered read, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    // entries never written since clear read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            rvalid_reg <= valid_reg[addr];
            if (we) begin
                valid_reg[addr] <= 1'b1;
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/rrs_serial_mul.sv =====
// ----------------------------------------------------------------------------
// rrs_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, product mod 2^64.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_serial_mul (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rrs_pkg::mul_req_t             req,
    output logic                               done,
    output logic [rrs_pkg::WIDE_BITS-1:0]      product
);

    logic [rrs_pkg::WIDE_BITS-1:0]   acc_reg, acc_next;
    logic [rrs_pkg::WIDE_BITS-1:0]   mcand_reg, mcand_next;
    logic [rrs_pkg::MPLIER_BITS-1:0] mplier_reg, mplier_next;
    logic [rrs_pkg::CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                            done_reg, done_next;

    // one partial product per cycle
    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (req.start) begin
            acc_next    = '0;
            mcand_next  = req.mcand;
            mplier_next = req.mplier;
            cnt_next    = req.nbits;
        end else if (cnt_reg != '0) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[rrs_pkg::WIDE_BITS-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[rrs_pkg::MPLIER_BITS-1:1]};
            cnt_next    = cnt_reg - 1'b1;
            done_next   = (cnt_reg == rrs_pkg::CNT_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/rrs_serial_div.sv =====
// ----------------------------------------------------------------------------
// rrs_serial_div
// Restoring divider, one quotient bit per cycle, Q2.12 saturated result.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_serial_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rrs_pkg::div_req_t             req,
    output logic                               done,
    output logic [rrs_pkg::BETA_BITS-1:0]      quotient
);

    logic [rrs_pkg::WIDE_BITS-1:0]    rem_reg, rem_next;
    logic [rrs_pkg::WIDE_BITS-1:0]    sh_reg, sh_next;
    logic [rrs_pkg::WIDE_BITS-1:0]    den_reg, den_next;
    logic [rrs_pkg::BETA_BITS-1:0]    q_reg, q_next;
    logic                             over_reg, over_next;
    logic [rrs_pkg::DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                             done_reg, done_next;
    logic [rrs_pkg::WIDE_BITS:0]      trial;
    logic                             ge;

    // dividend bits enter msb first, then the fraction zeros
    always_comb begin
        trial       = {rem_reg, sh_reg[rrs_pkg::WIDE_BITS-1]};
        ge          = (trial >= {1'b0, den_reg});
        rem_next    = rem_reg;
        sh_next     = sh_reg;
        den_next    = den_reg;
        q_next      = q_reg;
        over_next   = over_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            sh_next   = req.num;
            den_next  = req.den;
            q_next    = '0;
            over_next = 1'b0;
            cnt_next  = rrs_pkg::DIV_CNT_BITS'(rrs_pkg::DIV_STEPS);
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? rrs_pkg::WIDE_BITS'(trial - {1'b0, den_reg})
                           : trial[rrs_pkg::WIDE_BITS-1:0];
            sh_next   = {sh_reg[rrs_pkg::WIDE_BITS-2:0], 1'b0};
            q_next    = {q_reg[rrs_pkg::BETA_BITS-2:0], ge};
            // any quotient bit above the result width saturates
            over_next = over_reg | q_reg[rrs_pkg::BETA_BITS-1];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == rrs_pkg::DIV_CNT_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        over_reg <= over_next;
    end

    assign done     = done_reg;
    assign quotient = over_reg ? rrs_pkg::BETA_MAXCODE : q_reg;

endmodule

`default_nettype wire

// ===== rtl/rolling_regression_slope_core.sv =====
// ----------------------------------------------------------------------------
// rolling_regression_slope_core
// Rolling least-squares slope of y on x over a configurable window.
// ----------------------------------------------------------------------------
// Sequence: each input transfer runs nine products on a shift-add multiplier
//   (seven, and no divide, when the window is degenerate), then the slope
//   from a restoring divider (76 steps, one quotient bit each). The core
//   takes no new input until the previous item is in the output register;
//   a waiting result does not block the next input transfer. Reset
//   (synchronous, aresetn low) clears rings, sums and control registers to
//   defaults; a window_len write clears the window.
`default_nettype none

module rolling_regression_slope_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [23:0] x_sample, [47:24] y_sample
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [13:0] beta, [15:14] zero
    output logic [1:0]       m_tuser,   // [0] degenerate, [1] window_full
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    localparam int SB = rrs_pkg::SAMPLE_BITS;
    localparam int WB = rrs_pkg::WIDE_BITS;

    rrs_pkg::state_t state_reg, state_next;
    rrs_pkg::op_t    op_reg, op_next;

    logic [rrs_pkg::WLEN_BITS-1:0]  n_reg;
    logic [rrs_pkg::BETA_BITS-1:0]  bmin_reg, bmax_reg;
    logic [rrs_pkg::FLOOR_BITS-1:0] floor_reg;
    logic [rrs_pkg::WLEN_BITS-1:0]  wlen_sat;

    logic [SB-1:0]                  x_reg, y_reg;
    logic [SB-1:0]                  ox_reg, oy_reg;
    logic [rrs_pkg::SUM1_BITS-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic [rrs_pkg::SUM2_BITS-1:0]  sxy_reg, sxy_next, sxx_reg, sxx_next;
    logic [rrs_pkg::RING_AW-1:0]    wp_reg, wp_next;
    logic [rrs_pkg::WLEN_BITS-1:0]  fill_reg, fill_next;
    logic [WB-1:0]                  a_reg, a_next, den_reg, den_next, num_reg, num_next;
    logic                           degen_reg, degen_next;
    logic [rrs_pkg::BETA_BITS-1:0]  beta_reg, beta_next;

    logic                           m_valid_reg, m_valid_next;
    logic [rrs_pkg::BETA_BITS-1:0]  m_beta_reg, m_beta_next;
    logic                           m_degen_reg, m_degen_next;
    logic                           m_full_reg, m_full_next;

    logic                           in_xfer, clear_win;
    logic [rrs_pkg::WLEN_BITS-1:0]  wp_inc;
    logic [2*SB-1:0]                ring_rdata;
    logic [SB-1:0]                  ox, oy;

    rrs_pkg::mul_req_t              mreq;
    rrs_pkg::div_req_t              dreq;
    logic                           mul_done, div_done;
    logic [WB-1:0]                  prod;
    logic [rrs_pkg::BETA_BITS-1:0]  quot;

    assign s_tready  = (state_reg == rrs_pkg::ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign clear_win = cfg_we && (cfg_addr == rrs_pkg::REG_WINDOW_LEN);
    assign ox        = ring_rdata[SB-1:0];
    assign oy        = ring_rdata[2*SB-1:SB];
    assign wp_inc    = {1'b0, wp_reg} + 1'b1;

    // window length saturated into its legal range
    always_comb begin
        wlen_sat = cfg_wdata[rrs_pkg::WLEN_BITS-1:0];
        if (wlen_sat < rrs_pkg::WLEN_MIN) begin
            wlen_sat = rrs_pkg::WLEN_MIN;
        end else if (wlen_sat > rrs_pkg::WLEN_MAX) begin
            wlen_sat = rrs_pkg::WLEN_MAX;
        end
    end

    rrs_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (clear_win),
        .we      (in_xfer),
        .addr    (wp_reg),
        .wdata   (s_tdata),
        .rdata   (ring_rdata)
    );

    rrs_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .done    (mul_done),
        .product (prod)
    );

    rrs_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (dreq),
        .done     (div_done),
        .quotient (quot)
    );

    // multiplier operands for the current product
    always_comb begin
        mreq.start  = (state_reg == rrs_pkg::ST_ISSUE);
        mreq.mcand  = '0;
        mreq.mplier = '0;
        mreq.nbits  = rrs_pkg::CNT_BITS'(SB);
        case (op_reg)
            rrs_pkg::OP_XY: begin
                mreq.mcand  = WB'(x_reg);
                mreq.mplier = rrs_pkg::MPLIER_BITS'(y_reg);
            end
            rrs_pkg::OP_OXY: begin
                mreq.mcand  = WB'(ox_reg);
                mreq.mplier = rrs_pkg::MPLIER_BITS'(oy_reg);
            end
            rrs_pkg::OP_XX: begin
                mreq.mcand  = WB'(x_reg);
                mreq.mplier = rrs_pkg::MPLIER_BITS'(x_reg);
            end
            rrs_pkg::OP_OXX: begin
                mreq.mcand  = WB'(ox_reg);
                mreq.mplier = rrs_pkg::MPLIER_BITS'(ox_reg);
            end
            rrs_pkg::OP_NSXX: begin
                mreq.mcand  = WB'(sxx_reg);
                mreq.mplier = rrs_pkg::MPLIER_BITS'(n_reg);
                mreq.nbits  = rrs_pkg::CNT_BITS'(rrs_pkg::WLEN_BITS);
            end
            rrs_pkg::OP_SXSX: begin
                mreq.mcand  = WB'(sx_reg);
                mreq.mplier = sx_reg;
                mreq.nbits  = rrs_pkg::CNT_BITS'(rrs_pkg::SUM1_BITS);
            end
            rrs_pkg::OP_FLOOR: begin
                mreq.mcand  = WB'(floor_reg);
                mreq.mplier = rrs_pkg::MPLIER_BITS'(n_reg);
                mreq.nbits  = rrs_pkg::CNT_BITS'(rrs_pkg::WLEN_BITS);
            end
            rrs_pkg::OP_NSXY: begin
                mreq.mcand  = WB'(sxy_reg);
                mreq.mplier = rrs_pkg::MPLIER_BITS'(n_reg);
                mreq.nbits  = rrs_pkg::CNT_BITS'(rrs_pkg::WLEN_BITS);
            end
            rrs_pkg::OP_SXSY: begin
                mreq.mcand  = WB'(sx_reg);
                mreq.mplier = sy_reg;
                mreq.nbits  = rrs_pkg::CNT_BITS'(rrs_pkg::SUM1_BITS);
            end
            default: begin
                mreq.mcand  = '0;
            end
        endcase
    end

    // sequencer: next state, sums and result
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        sxy_next     = sxy_reg;
        sxx_next     = sxx_reg;
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        a_next       = a_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        degen_next   = degen_reg;
        beta_next    = beta_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_beta_next  = m_beta_reg;
        m_degen_next = m_degen_reg;
        m_full_next  = m_full_reg;
        dreq.start   = 1'b0;
        dreq.num     = num_reg;
        dreq.den     = den_reg;

        case (state_reg)
            rrs_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    wp_next    = (wp_inc >= n_reg) ? '0 : wp_inc[rrs_pkg::RING_AW-1:0];
                    if (fill_reg < n_reg) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = rrs_pkg::ST_READ;
                end
            end
            rrs_pkg::ST_READ: begin
                // leaving pair comes out of the ring this cycle
                sx_next    = sx_reg - rrs_pkg::SUM1_BITS'(ox) + rrs_pkg::SUM1_BITS'(x_reg);
                sy_next    = sy_reg - rrs_pkg::SUM1_BITS'(oy) + rrs_pkg::SUM1_BITS'(y_reg);
                op_next    = rrs_pkg::OP_XY;
                state_next = rrs_pkg::ST_ISSUE;
            end
            rrs_pkg::ST_ISSUE: begin
                state_next = rrs_pkg::ST_WAIT;
            end
            rrs_pkg::ST_WAIT: begin
                if (mul_done) begin
                    state_next = rrs_pkg::ST_ISSUE;
                    case (op_reg)
                        rrs_pkg::OP_XY: begin
                            sxy_next = sxy_reg + prod[rrs_pkg::SUM2_BITS-1:0];
                            op_next  = rrs_pkg::OP_OXY;
                        end
                        rrs_pkg::OP_OXY: begin
                            sxy_next = sxy_reg - prod[rrs_pkg::SUM2_BITS-1:0];
                            op_next  = rrs_pkg::OP_XX;
                        end
                        rrs_pkg::OP_XX: begin
                            sxx_next = sxx_reg + prod[rrs_pkg::SUM2_BITS-1:0];
                            op_next  = rrs_pkg::OP_OXX;
                        end
                        rrs_pkg::OP_OXX: begin
                            sxx_next = sxx_reg - prod[rrs_pkg::SUM2_BITS-1:0];
                            op_next  = rrs_pkg::OP_NSXX;
                        end
                        rrs_pkg::OP_NSXX: begin
                            a_next  = prod;
                            op_next = rrs_pkg::OP_SXSX;
                        end
                        rrs_pkg::OP_SXSX: begin
                            den_next = (a_reg > prod) ? a_reg - prod : '0;
                            op_next  = rrs_pkg::OP_FLOOR;
                        end
                        rrs_pkg::OP_FLOOR: begin
                            // zero or small denominator forces a slope of one
                            degen_next = (den_reg == '0) || (den_reg < prod);
                            op_next    = rrs_pkg::OP_NSXY;
                            if (degen_next) begin
                                beta_next  = rrs_pkg::BETA_ONE;
                                state_next = rrs_pkg::ST_DONE;
                            end
                        end
                        rrs_pkg::OP_NSXY: begin
                            a_next  = prod;
                            op_next = rrs_pkg::OP_SXSY;
                        end
                        rrs_pkg::OP_SXSY: begin
                            num_next   = (a_reg > prod) ? a_reg - prod : '0;
                            state_next = rrs_pkg::ST_DIV;
                        end
                        default: begin
                            state_next = rrs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rrs_pkg::ST_DIV: begin
                dreq.start = (op_reg == rrs_pkg::OP_SXSY);
                op_next    = rrs_pkg::OP_XY;
                if (div_done) begin
                    beta_next = quot;
                    if (beta_next < bmin_reg) begin
                        beta_next = bmin_reg;
                    end
                    if (beta_next > bmax_reg) begin
                        beta_next = bmax_reg;
                    end
                    state_next = rrs_pkg::ST_DONE;
                end
            end
            rrs_pkg::ST_DONE: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_beta_next  = beta_reg;
                    m_degen_next = degen_reg;
                    m_full_next  = (fill_reg >= n_reg);
                    state_next   = rrs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrs_pkg::ST_IDLE;
            end
        endcase

        // a window length write restarts the window
        if (clear_win) begin
            sx_next   = '0;
            sy_next   = '0;
            sxy_next  = '0;
            sxx_next  = '0;
            wp_next   = '0;
            fill_next = '0;
        end
    end

    // control, window state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rrs_pkg::ST_IDLE;
            op_reg      <= rrs_pkg::OP_XY;
            sx_reg      <= '0;
            sy_reg      <= '0;
            sxy_reg     <= '0;
            sxx_reg     <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            n_reg       <= rrs_pkg::WLEN_RESET;
            bmin_reg    <= rrs_pkg::BMIN_RESET;
            bmax_reg    <= rrs_pkg::BMAX_RESET;
            floor_reg   <= rrs_pkg::FLOOR_RESET;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            sxy_reg     <= sxy_next;
            sxx_reg     <= sxx_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    rrs_pkg::REG_WINDOW_LEN:  n_reg     <= wlen_sat;
                    rrs_pkg::REG_BETA_MIN:    bmin_reg  <= cfg_wdata[rrs_pkg::BETA_BITS-1:0];
                    rrs_pkg::REG_BETA_MAX:    bmax_reg  <= cfg_wdata[rrs_pkg::BETA_BITS-1:0];
                    rrs_pkg::REG_DENOM_FLOOR: floor_reg <= cfg_wdata;
                    default:                  floor_reg <= floor_reg;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            x_reg <= s_tdata[SB-1:0];
            y_reg <= s_tdata[2*SB-1:SB];
        end
        // leaving pair held for its products after the ring moves on
        if (state_reg == rrs_pkg::ST_READ) begin
            ox_reg <= ox;
            oy_reg <= oy;
        end
        a_reg       <= a_next;
        den_reg     <= den_next;
        num_reg     <= num_next;
        degen_reg   <= degen_next;
        beta_reg    <= beta_next;
        m_beta_reg  <= m_beta_next;
        m_degen_reg <= m_degen_next;
        m_full_reg  <= m_full_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_beta_reg};
    assign m_tuser  = {m_full_reg, m_degen_reg};

endmodule

`default_nettype wire

// ===== rtl/rrs_checker.sv =====
// ----------------------------------------------------------------------------
// rrs_checker
// Port-level checks for the rolling regression slope core.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a result waiting for its transfer stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    // one item in work at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a degenerate window always reports a slope of one
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[13:0] == 14'd4096)
        else $error("degenerate result not one");

    // padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:14] == 2'b00)
        else $error("nonzero padding");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rolling_regression_slope_core rrs_checker u_rrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
